FILE: sv/idr_pkg.sv
package idr_pkg;
    localparam int unsigned ExpW  = 11;
    localparam int unsigned MantW = 53;
    localparam logic [63:0] QNAN  = 64'h7FF8_0000_0000_0000;
    localparam logic [10:0] ExpAll = 11'h7FF;

    typedef struct packed {
        logic load;   // capture operands, set up division
        logic step;   // one shift-subtract iteration
        logic fin;    // final compare and round-to-even fix-up
        logic norm;   // one normalize shift
        logic pack;   // build result word
    } t_cmd;

    typedef struct packed {
        logic special;   // result settled at load
        logic div_done;  // no iterations left
        logic norm_done; // zero, normalized, or minimum scale reached
    } t_sts;
endpackage

FILE: sv/ieee_double_remainder_unit.sv
// IEEE 754 binary64 remainder (x - n*y, n nearest x/y, ties to even), exact.
// One word at a time: after acceptance the word is loaded and checked, then runs
// the single shift-subtract loop over the exponent difference, the final rounding
// step, the normalize shifts and packing; the result is then held until taken.
// Special cases go from the check state straight to the output state.
// NaN operands, zero y or infinite x give the default quiet NaN with the invalid
// flag; infinite y returns x.
module ieee_double_remainder_unit
    import idr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [63:0] i_dividend_bits,
    input  logic [63:0] i_divisor_bits,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [63:0] o_remainder_bits,
    output logic        o_invalid_flag
);
    t_cmd cmd;
    t_sts sts;

    idr_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
        .o_valid(o_valid), .i_ready(i_ready), .i_sts(sts), .o_cmd(cmd)
    );

    idr_datapath u_dp (
        .i_clk(i_clk), .i_dividend_bits(i_dividend_bits),
        .i_divisor_bits(i_divisor_bits), .i_cmd(cmd), .o_sts(sts),
        .o_remainder_bits(o_remainder_bits), .o_invalid_flag(o_invalid_flag)
    );
endmodule

FILE: sv/idr_datapath.sv
module idr_datapath
    import idr_pkg::*;
(
    input  logic        i_clk,
    input  logic [63:0] i_dividend_bits,
    input  logic [63:0] i_divisor_bits,
    input  t_cmd        i_cmd,
    output t_sts        o_sts,
    output logic [63:0] o_remainder_bits,
    output logic        o_invalid_flag
);
    logic [63:0] r_x, n_x;
    logic [63:0] r_res, n_res;
    logic        r_inv, n_inv;
    logic        r_special, n_special;
    logic [63:0] r_m, n_m;
    logic [63:0] r_big, n_big;
    logic [52:0] r_my, n_my;
    logic [11:0] r_cnt, n_cnt;
    logic [10:0] r_scale, n_scale;
    logic        r_sign, n_sign;

    logic [10:0] fx, fy;
    logic [51:0] tx, ty;
    logic [10:0] ex, ey;
    logic [52:0] mx, my;
    logic [63:0] m_sub, m2;
    logic        ge;
    logic [63:0] fin_m;
    logic [63:0] fin_m2;
    logic        fin_odd;

    assign fx = i_dividend_bits[62:52];
    assign fy = i_divisor_bits[62:52];
    assign tx = i_dividend_bits[51:0];
    assign ty = i_divisor_bits[51:0];
    assign ex = (fx == '0) ? 11'd1 : fx;
    assign ey = (fy == '0) ? 11'd1 : fy;
    assign mx = {(fx != '0), tx};
    assign my = {(fy != '0), ty};

    // the partial remainder is kept as a full 64-bit word and wraps at that width
    assign ge    = r_m >= {11'd0, r_my};
    assign m_sub = ge ? (r_m - {11'd0, r_my}) : r_m;
    assign m2    = {r_m[62:0], 1'b0};

    // datapath registers
    always_comb begin
        n_x = r_x; n_res = r_res; n_inv = r_inv; n_special = r_special;
        n_m = r_m; n_big = r_big; n_my = r_my; n_cnt = r_cnt;
        n_scale = r_scale; n_sign = r_sign;
        fin_m = r_m;
        fin_m2 = '0;
        fin_odd = 1'b0;
        if (i_cmd.load) begin
            n_x = i_dividend_bits;
            n_sign = i_dividend_bits[63];
            n_my = my;
            n_inv = 1'b0;
            n_special = 1'b1;
            n_m = {11'd0, mx};
            n_res = i_dividend_bits;
            if ((fx == ExpAll) || ((fy == ExpAll) && (ty != '0)) ||
                    ((fy == '0) && (ty == '0))) begin
                n_res = QNAN;
                n_inv = 1'b1;
            end else if (fy == ExpAll) begin
                n_res = i_dividend_bits;
            end else if (ex >= ey) begin
                n_special = 1'b0;
                n_cnt = {1'b0, ex - ey};
                n_big = {11'd0, my};
                n_scale = ey;
            end else if (ey == ex + 11'd1) begin
                // quotient zero or one: mark counter as "no division, not odd"
                n_special = 1'b0;
                n_cnt = '1;
                n_big = {10'd0, my, 1'b0};
                n_scale = ex;
            end
        end else if (i_cmd.step) begin
            n_m = {m_sub[62:0], 1'b0};
            n_cnt = r_cnt - 12'd1;
        end else if (i_cmd.fin) begin
            // last subtract gives quotient parity, then round to nearest even
            if (r_cnt == 12'd0 && ge) begin
                fin_m   = r_m - {11'd0, r_my};
                fin_odd = 1'b1;
            end
            fin_m2 = {fin_m[62:0], 1'b0};
            if ((fin_m2 > r_big) || ((fin_m2 == r_big) && fin_odd)) begin
                fin_m = r_big - fin_m;
                if (fin_m != '0) n_sign = ~r_sign;
            end
            n_m = fin_m;
        end else if (i_cmd.norm) begin
            n_m = m2;
            n_scale = r_scale - 11'd1;
        end else if (i_cmd.pack) begin
            if (r_m == '0)
                n_res = {r_x[63], 63'd0};
            else if (r_m[63:52] != '0)
                n_res = {r_sign, r_scale, r_m[51:0]};
            else
                n_res = {r_sign, 11'd0, r_m[51:0]};
        end
    end

    always_ff @(posedge i_clk) begin
        r_x <= n_x; r_res <= n_res; r_inv <= n_inv; r_special <= n_special;
        r_m <= n_m; r_big <= n_big; r_my <= n_my; r_cnt <= n_cnt;
        r_scale <= n_scale; r_sign <= n_sign;
    end

    assign o_sts.special   = r_special;
    assign o_sts.div_done  = (r_cnt == 12'd0) || (r_cnt == '1);
    assign o_sts.norm_done = (r_m == '0) || (r_m[63:52] != '0) || (r_scale <= 11'd1);
    assign o_remainder_bits = r_res;
    assign o_invalid_flag   = r_inv;
endmodule

FILE: sv/idr_ctrl.sv
module idr_ctrl
    import idr_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    output logic o_valid,
    input  logic i_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);
    localparam logic [2:0] S_IDLE = 3'd0, S_CHK = 3'd1, S_DIV = 3'd2,
                           S_FIN = 3'd3, S_NORM = 3'd4, S_PACK = 3'd5,
                           S_OUT = 3'd6;
    logic [2:0] r_state, n_state;

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = (r_state == S_OUT);

    // sequence one word through the datapath
    always_comb begin
        n_state = r_state;
        o_cmd = '0;
        unique case (r_state)
            S_IDLE: if (i_valid) begin
                o_cmd.load = 1'b1;
                n_state = S_CHK;
            end
            S_CHK:  n_state = i_sts.special ? S_OUT : S_DIV;
            S_DIV:  if (i_sts.div_done) n_state = S_FIN;
                    else o_cmd.step = 1'b1;
            S_FIN: begin
                o_cmd.fin = 1'b1;
                n_state = S_NORM;
            end
            S_NORM: if (i_sts.norm_done) n_state = S_PACK;
                    else o_cmd.norm = 1'b1;
            S_PACK: begin
                o_cmd.pack = 1'b1;
                n_state = S_OUT;
            end
            S_OUT:  if (i_ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else r_state <= n_state;
    end

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> o_valid) else $error("result dropped");
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_ready && o_valid)) else $error("ready while result pending");
    a_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(o_cmd)) else $error("multiple commands");
endmodule

FILE: tb/tb_ieee_double_remainder_unit.sv
module tb_ieee_double_remainder_unit;
    import idr_pkg::*;

    localparam logic [63:0] FracMask  = 64'h000F_FFFF_FFFF_FFFF;
    localparam logic [63:0] HiddenBit = 64'h0010_0000_0000_0000;
    localparam logic [63:0] SignBit   = 64'h8000_0000_0000_0000;
    localparam int unsigned CycleLimit = 4000000;

    typedef struct packed {
        logic [63:0] rem;
        logic        inv;
    } t_rem_word;

    // Build a binary64 word from sign, magnitude and scale, normalizing as needed.
    function automatic logic [63:0] pack_rem(logic [63:0] sgn, logic [63:0] mag,
                                             logic [10:0] scale);
        logic [63:0] m;
        logic [10:0] s;
        m = mag;
        s = scale;
        if (m == 0) return sgn;
        while (m < HiddenBit && s > 1) begin
            m = m << 1;
            s = s - 1;
        end
        if (m >= HiddenBit) return sgn | ({53'd0, s} << 52) | (m & FracMask);
        return sgn | m;
    endfunction

    // Exact IEEE remainder by long division over the exponent difference.
    function automatic t_rem_word calc_remainder(logic [63:0] x, logic [63:0] y);
        t_rem_word r;
        logic [63:0] sx, mx, my, m, big;
        logic [10:0] fx, fy, ex, ey, scale;
        logic odd;
        int i;
        sx = x & SignBit;
        fx = x[62:52];
        fy = y[62:52];
        odd = 1'b0;
        r.inv = 1'b0;
        if ((fx == ExpAll && x[51:0] != 0) || (fy == ExpAll && y[51:0] != 0) ||
            (fy == 0 && y[51:0] == 0) || fx == ExpAll) begin
            r.rem = QNAN;
            r.inv = 1'b1;
            return r;
        end
        if (fy == ExpAll) begin
            r.rem = x;
            return r;
        end
        ex = (fx != 0) ? fx : 11'd1;
        ey = (fy != 0) ? fy : 11'd1;
        mx = (fx != 0) ? ((x & FracMask) | HiddenBit) : (x & FracMask);
        my = (fy != 0) ? ((y & FracMask) | HiddenBit) : (y & FracMask);
        if (ex >= ey) begin
            m = mx;
            for (i = ex; i > ey; i--) begin
                if (m >= my) m = m - my;
                m = m << 1;
            end
            if (m >= my) begin
                m = m - my;
                odd = 1'b1;
            end
            big = my;
            scale = ey;
        end else if (ey == ex + 1) begin
            m = mx;
            big = my << 1;
            scale = ex;
        end else begin
            r.rem = x;
            return r;
        end
        if ((m << 1) > big || ((m << 1) == big && odd)) begin
            m = big - m;
            sx = sx ^ SignBit;
        end
        if (m == 0) sx = x & SignBit;
        r.rem = pack_rem(sx, m, scale);
        return r;
    endfunction

    int errors = 0;

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] exp_v);
        $display("mismatch %s: got %h expected %h", what, got, exp_v);
        errors++;
    endtask

    class rem_scoreboard;
        t_rem_word pending[$];

        function void note_operands(logic [63:0] x, logic [63:0] y);
            pending.push_back(calc_remainder(x, y));
        endfunction

        task check_word(logic [63:0] rem, logic inv);
            t_rem_word e;
            if (pending.size() == 0) begin
                report_mismatch("unexpected word", rem, 64'd0);
            end else begin
                e = pending.pop_front();
                if (rem !== e.rem) report_mismatch("remainder_bits", rem, e.rem);
                if (inv !== e.inv) report_mismatch("invalid_flag", {63'd0, inv}, {63'd0, e.inv});
            end
        endtask
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        i_ready = 1'b0;
    logic [63:0] i_dividend_bits = '0;
    logic [63:0] i_divisor_bits = '0;
    logic        o_ready, o_valid, o_invalid_flag;
    logic [63:0] o_remainder_bits;

    ieee_double_remainder_unit u_top (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    rem_scoreboard sb = new();
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int cycles = 0;

    // Watch the cycle budget.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit) begin
            $display("FAIL");
            $finish;
        end
    end

    // Check results at the rising edge.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) sb.check_word(o_remainder_bits, o_invalid_flag);
    end

    // Randomly stall the receiver.
    always @(negedge i_clk) begin
        i_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Present a word at the falling edge and hold it until the block takes it.
    task automatic send_operands(logic [63:0] x, logic [63:0] y);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_dividend_bits <= x;
        i_divisor_bits <= y;
        while (!o_ready) @(negedge i_clk);
        @(posedge i_clk);
        sb.note_operands(x, y);
        @(negedge i_clk);
    endtask

    // Mostly small exponent gaps, with a few spanning the full range.
    function automatic logic [63:0] rand_double(logic [10:0] near_exp);
        logic [63:0] v;
        int sel;
        v = {$urandom, $urandom};
        sel = $urandom_range(99);
        if (sel < 70) v[62:52] = near_exp + 11'($urandom_range(80)) - 11'd40;
        else if (sel < 80) v[62:52] = 11'd0;
        else if (sel < 83) v[62:52] = ExpAll;
        else if (sel < 86) v[51:0] = '0;
        return v;
    endfunction

    task automatic send_random(int count);
        logic [10:0] e;
        for (int k = 0; k < count; k++) begin
            e = 11'($urandom_range(2046));
            send_operands(rand_double(e), rand_double(e));
        end
    endtask

    // Drop valid and hold off until every expected word has come back.
    task automatic wait_drained();
        i_valid <= 1'b0;
        while (sb.pending.size() != 0) @(negedge i_clk);
    endtask

    initial begin
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: extremes and every special case.
        send_operands(64'h7FF8_0000_0000_0001, 64'h3FF0_0000_0000_0000);
        send_operands(64'h3FF0_0000_0000_0000, 64'hFFF0_0000_0000_0001);
        send_operands(64'h3FF0_0000_0000_0000, 64'h0000_0000_0000_0000);
        send_operands(64'h3FF0_0000_0000_0000, 64'h8000_0000_0000_0000);
        send_operands(64'h7FF0_0000_0000_0000, 64'h3FF0_0000_0000_0000);
        send_operands(64'hFFF0_0000_0000_0000, 64'h7FF0_0000_0000_0000);
        send_operands(64'hC008_0000_0000_0000, 64'h7FF0_0000_0000_0000);
        send_operands(64'h0000_0000_0000_0000, 64'h4000_0000_0000_0000);
        send_operands(64'h8000_0000_0000_0000, 64'h0000_0000_0000_0001);
        send_operands(64'h4014_0000_0000_0000, 64'h4000_0000_0000_0000);
        send_operands(64'h4008_0000_0000_0000, 64'h4000_0000_0000_0000);
        send_operands(64'hC014_0000_0000_0000, 64'h4000_0000_0000_0000);
        send_operands(64'h4010_0000_0000_0000, 64'h4000_0000_0000_0000);
        send_operands(64'h7FEF_FFFF_FFFF_FFFF, 64'h0000_0000_0000_0001);
        send_operands(64'h7FEF_FFFF_FFFF_FFFF, 64'h000F_FFFF_FFFF_FFFF);
        send_operands(64'h0000_0000_0000_0003, 64'h0000_0000_0000_0002);
        send_operands(64'h000F_FFFF_FFFF_FFFF, 64'h0010_0000_0000_0001);
        send_operands(64'h3FF0_0000_0000_0000, 64'h7FEF_FFFF_FFFF_FFFF);
        send_operands(64'h3FE8_0000_0000_0000, 64'h3FF0_0000_0000_0000);
        send_operands(64'h3FE0_0000_0000_0000, 64'hBFF0_0000_0000_0000);
        send_operands(64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
        send_operands(64'h7FEF_FFFF_FFFF_FFFF, 64'hFFEF_FFFF_FFFF_FFFF);

        // Random phases with varying idle and stall pressure.
        send_random(65);
        wait_drained();
        send_idle_pct = 51;
        send_random(65);
        send_idle_pct = 0;
        recv_stall_pct = 51;
        send_random(65);
        send_idle_pct = 19;
        recv_stall_pct = 19;
        send_random(65);

        wait_drained();
        repeat (2200) @(negedge i_clk);
        if (errors == 0 && sb.pending.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end
endmodule
